// ===== rtl/core/cmc_pkg.sv =====
package cmc_pkg;

    localparam int MAX_POINTS_DEF    = 65536;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COORD_W = 24;
    localparam int COLOR_W = 17;
    localparam int SUM_W   = 40;
    localparam int PSUM_W  = 64;
    localparam int COV_W   = 40;
    localparam int DIVX_W  = 65;
    localparam int DIV_W   = 66;
    localparam int QDEPTH  = 2;
    localparam int NMEAN   = 3;
    localparam int NPAIR   = 6;

    localparam logic [1:0] PAIR_I [NPAIR] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_J [NPAIR] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    localparam logic STAT_POSITION = 1'b0;
    localparam logic STAT_COLOR    = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_a;
        logic signed [COORD_W-1:0] coord_b;
        logic signed [COORD_W-1:0] coord_c;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic                      last_point;
    } in_t;

    typedef struct packed {
        logic                      statistic;
        logic signed [COORD_W-1:0] mean_a;
        logic signed [COORD_W-1:0] mean_b;
        logic signed [COORD_W-1:0] mean_c;
        logic signed [COV_W-1:0]   cov_aa;
        logic signed [COV_W-1:0]   cov_ab;
        logic signed [COV_W-1:0]   cov_ac;
        logic signed [COV_W-1:0]   cov_bb;
        logic signed [COV_W-1:0]   cov_bc;
        logic signed [COV_W-1:0]   cov_cc;
        logic                      final_result;
    } out_t;

    typedef struct packed {
        logic [NMEAN-1:0][SUM_W-1:0]  pos_sum;
        logic [NMEAN-1:0][SUM_W-1:0]  col_sum;
        logic [NPAIR-1:0][PSUM_W-1:0] pos_prod;
        logic [NPAIR-1:0][PSUM_W-1:0] col_prod;
    } snap_t;

endpackage

// ===== rtl/core/cmc_front.sv =====
module cmc_front
    import cmc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int CW         = $clog2(MAX_POINTS + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  in_t           in_item,
    input  logic          q_full,
    output logic          in_ready,
    output logic          q_push,
    output snap_t         q_snap,
    output logic [CW-1:0] q_count
);

    logic [CW-1:0] cnt_reg, cnt_next;
    snap_t         acc_reg, acc_next;
    logic          accept, take;
    logic signed [COORD_W-1:0] pv [NMEAN];
    logic [COLOR_W-1:0]        cv [NMEAN];
    logic signed [2*COORD_W-1:0] pp [NPAIR];
    logic [2*COLOR_W-1:0]        cp [NPAIR];

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign take     = accept && (cnt_reg < CW'(MAX_POINTS));

    always_comb
    begin
        pv[0] = in_item.coord_a;
        pv[1] = in_item.coord_b;
        pv[2] = in_item.coord_c;
        cv[0] = in_item.red;
        cv[1] = in_item.green;
        cv[2] = in_item.blue;
        for (int k = 0; k < NPAIR; k++)
        begin
            pp[k] = pv[PAIR_I[k]] * pv[PAIR_J[k]];
            cp[k] = cv[PAIR_I[k]] * cv[PAIR_J[k]];
        end
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (take)
        begin
            cnt_next = cnt_reg + 1'b1;
            for (int k = 0; k < NMEAN; k++)
            begin
                acc_next.pos_sum[k] = acc_reg.pos_sum[k]
                                      + {{(SUM_W-COORD_W){pv[k][COORD_W-1]}}, pv[k]};
                acc_next.col_sum[k] = acc_reg.col_sum[k]
                                      + {{(SUM_W-COLOR_W){1'b0}}, cv[k]};
            end
            for (int k = 0; k < NPAIR; k++)
            begin
                acc_next.pos_prod[k] = acc_reg.pos_prod[k]
                    + {{(PSUM_W-2*COORD_W){pp[k][2*COORD_W-1]}}, pp[k]};
                acc_next.col_prod[k] = acc_reg.col_prod[k]
                    + {{(PSUM_W-2*COLOR_W){1'b0}}, cp[k]};
            end
        end
    end

    assign q_push  = accept && in_item.last_point;
    assign q_snap  = acc_next;
    assign q_count = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            acc_reg <= '0;
        end
        else if (q_push)
        begin
            cnt_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== rtl/core/cmc_queue.sv =====
module cmc_queue
    import cmc_pkg::*;
#(
    parameter int CW = $clog2(MAX_POINTS_DEF + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  snap_t         push_snap,
    input  logic [CW-1:0] push_count,
    output logic          full,
    output logic          valid,
    output snap_t         head_snap,
    output logic [CW-1:0] head_count,
    input  logic          pop
);

    localparam int PW = $clog2(QDEPTH);

    snap_t         snap_mem [QDEPTH];
    logic [CW-1:0] cnt_mem  [QDEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   fill_reg;

    assign full       = (fill_reg == (PW+1)'(QDEPTH));
    assign valid      = (fill_reg != '0);
    assign head_snap  = snap_mem[rd_reg];
    assign head_count = cnt_mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            snap_mem[wr_reg] <= push_snap;
            cnt_mem[wr_reg]  <= push_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_reg <= (wr_reg == PW'(QDEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop && valid)
                rd_reg <= (rd_reg == PW'(QDEPTH-1)) ? '0 : rd_reg + 1'b1;
            fill_reg <= fill_reg + (PW+1)'(push && !full) - (PW+1)'(pop && valid);
        end
    end

endmodule

// ===== rtl/core/cmc_divider.sv =====
module cmc_divider
    import cmc_pkg::*;
#(
    parameter int CW = $clog2(MAX_POINTS_DEF + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DIVX_W-1:0] x,
    input  logic [CW-1:0]            d,
    output logic                     done,
    output logic signed [DIV_W-1:0]  q
);

    localparam int IW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [CW:0]      rem_reg;
    logic [CW-1:0]    d_reg;
    logic             neg_reg, busy_reg;
    logic [IW-1:0]    it_reg;
    logic signed [DIV_W-1:0] y;
    logic [CW+1:0]    trial;
    logic [CW+1:0]    diff;

    assign y     = DIV_W'(x) + DIV_W'(d >> 1);
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {2'b00, d_reg};
    assign done  = busy_reg && (it_reg == '0);

    always_comb
    begin
        if (!neg_reg)
            q = quo_reg;
        else if (rem_reg != '0)
            q = -(quo_reg + 1'b1);
        else
            q = -quo_reg;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= y[DIV_W-1] ? -y : y;
            rem_reg <= '0;
            d_reg   <= d;
            neg_reg <= y[DIV_W-1];
        end
        else if (busy_reg && it_reg != '0)
        begin
            if (!diff[CW+1])
            begin
                rem_reg <= diff[CW:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[CW:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            it_reg   <= IW'(DIV_W);
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg)
            it_reg <= it_reg - 1'b1;
    end

endmodule

// ===== rtl/core/cmc_back.sv =====
module cmc_back
    import cmc_pkg::*;
#(
    parameter int CW            = $clog2(MAX_POINTS_DEF + 1),
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  snap_t         q_snap,
    input  logic [CW-1:0] q_count,
    output logic          q_pop,
    output logic          out_valid,
    output out_t          out_item,
    input  logic          out_pop
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_COV  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    localparam logic [3:0] K_LAST = 4'(NMEAN + NPAIR - 1);

    state_t state_reg, state_next;
    logic [3:0] k_reg, k_next;
    logic stat_reg, stat_next;
    logic signed [COORD_W-1:0]   mean_reg [NMEAN];
    logic signed [63:0]          e_reg;
    logic signed [2*COORD_W-1:0] prod_reg;
    logic signed [COV_W-1:0]     cov_reg [NPAIR];
    out_t out_reg;
    logic out_valid_reg;

    logic [2:0] pidx;
    logic [1:0] midx;
    logic signed [DIVX_W-1:0] opnd;
    logic div_start, div_done;
    logic signed [DIV_W-1:0] div_q;
    logic signed [DIV_W-1:0] diff, rnd;
    logic signed [COV_W-1:0] cov_sat;
    logic signed [COORD_W-1:0] mean_sat;
    logic signed [63:0] e_sat;
    logic out_free;

    assign pidx = 3'(k_reg - 4'(NMEAN));
    assign midx = k_reg[1:0];

    always_comb
    begin
        if (k_reg < 4'(NMEAN))
        begin
            if (stat_reg == STAT_POSITION)
                opnd = DIVX_W'(signed'(q_snap.pos_sum[midx]));
            else
                opnd = DIVX_W'({1'b0, q_snap.col_sum[midx]});
        end
        else if (stat_reg == STAT_POSITION)
            opnd = DIVX_W'(signed'(q_snap.pos_prod[pidx]));
        else
            opnd = DIVX_W'(signed'(q_snap.col_prod[pidx]));
    end

    assign div_start = (state_reg == ST_LOAD);

    cmc_divider #(.CW(CW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (opnd),
        .d     (q_count),
        .done  (div_done),
        .q     (div_q)
    );

    always_comb
    begin
        if (div_q > DIV_W'(signed'(24'sh7FFFFF)))
            mean_sat = 24'sh7FFFFF;
        else if (div_q < DIV_W'(signed'(24'sh800000)))
            mean_sat = 24'sh800000;
        else
            mean_sat = div_q[COORD_W-1:0];
        if (div_q > (DIV_W'(1) <<< 62))
            e_sat = 64'sh4000000000000000;
        else if (div_q < -(DIV_W'(1) <<< 62))
            e_sat = -64'sh4000000000000000;
        else
            e_sat = div_q[63:0];
        diff = DIV_W'(e_reg) - DIV_W'(prod_reg);
        rnd  = (diff + (DIV_W'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
        if (rnd > DIV_W'(signed'(40'sh7FFFFFFFFF)))
            cov_sat = 40'sh7FFFFFFFFF;
        else if (rnd < DIV_W'(signed'(40'sh8000000000)))
            cov_sat = 40'sh8000000000;
        else
            cov_sat = rnd[COV_W-1:0];
    end

    assign out_free = !out_valid_reg || out_pop;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        stat_next  = stat_reg;
        q_pop      = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    k_next     = '0;
                    stat_next  = STAT_POSITION;
                    state_next = ST_LOAD;
                end
            ST_LOAD:
                state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                begin
                    if (k_reg < 4'(NMEAN))
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                        state_next = ST_MUL;
                end
            ST_MUL:
                state_next = ST_COV;
            ST_COV:
                if (k_reg == K_LAST)
                    state_next = ST_EMIT;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            ST_EMIT:
                if (out_free)
                begin
                    k_next = '0;
                    if (stat_reg == STAT_POSITION)
                    begin
                        stat_next  = STAT_COLOR;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        q_pop      = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV && div_done)
        begin
            if (k_reg < 4'(NMEAN))
                mean_reg[midx] <= mean_sat;
            else
                e_reg <= e_sat;
        end
        if (state_reg == ST_MUL)
            prod_reg <= mean_reg[PAIR_I[pidx]] * mean_reg[PAIR_J[pidx]];
        if (state_reg == ST_COV)
            cov_reg[pidx] <= cov_sat;
        if (state_reg == ST_EMIT && out_free)
        begin
            out_reg.statistic    <= stat_reg;
            out_reg.mean_a       <= mean_reg[0];
            out_reg.mean_b       <= mean_reg[1];
            out_reg.mean_c       <= mean_reg[2];
            out_reg.cov_aa       <= cov_reg[0];
            out_reg.cov_ab       <= cov_reg[1];
            out_reg.cov_ac       <= cov_reg[2];
            out_reg.cov_bb       <= cov_reg[3];
            out_reg.cov_bc       <= cov_reg[4];
            out_reg.cov_cc       <= cov_reg[5];
            out_reg.final_result <= stat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            stat_reg      <= STAT_POSITION;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            stat_reg  <= stat_next;
            if (state_reg == ST_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_pop)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== rtl/core/cell_mean_covariance.sv =====
// Mean and biased covariance of the points of one cell. Points transfer at one per cycle
// while the two-entry cell queue has room; the point with last_point set closes the cell
// and yields two results, position then color. Each cell is finished by one shared
// bit-serial divider, overlapping the accumulation of later cells: a division loads, forms
// the 66 quotient bits one at a time and finishes, and each of the six covariance terms
// adds a multiply and a covariance step. A result held on the outputs stalls the back
// end; the queue then fills and full rises.
module cell_mean_covariance
    import cmc_pkg::*;
#(
    parameter int MAX_POINTS    = MAX_POINTS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  in_item,
    output logic empty,
    input  logic pop,
    output out_t out_item
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    logic          q_full, q_push, q_valid, q_pop, in_ready, out_valid;
    snap_t         push_snap, head_snap;
    logic [CW-1:0] push_count, head_count;

    cmc_front #(.MAX_POINTS(MAX_POINTS), .CW(CW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (push),
        .in_item  (in_item),
        .q_full   (q_full),
        .in_ready (in_ready),
        .q_push   (q_push),
        .q_snap   (push_snap),
        .q_count  (push_count)
    );

    cmc_queue #(.CW(CW)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_snap  (push_snap),
        .push_count (push_count),
        .full       (q_full),
        .valid      (q_valid),
        .head_snap  (head_snap),
        .head_count (head_count),
        .pop        (q_pop)
    );

    cmc_back #(.CW(CW), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_snap    (head_snap),
        .q_count   (head_count),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_item  (out_item),
        .out_pop   (pop)
    );

    assign full  = !in_ready;
    assign empty = !out_valid;

endmodule

// ===== rtl/core/cmc_checker.sv =====
module cmc_sva
    import cmc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic empty,
    input logic pop,
    input out_t out_item
);

    a_final_matches_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> out_item.final_result == out_item.statistic)
        else $error("final_result differs from statistic");

    a_color_follows_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && out_item.statistic == STAT_POSITION)
        |=> (empty || out_item.statistic == STAT_COLOR))
        else $error("position result not followed by color result");

    a_gap_after_color: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && out_item.statistic == STAT_COLOR) |=> empty)
        else $error("result shown right after color result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("stalled result changed");

endmodule

bind cell_mean_covariance cmc_sva u_cmc_sva (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
